### sv/tbsp_pkg.sv
package tbsp_pkg;

    localparam int VAR_W      = 13;
    localparam int STEP_W     = 48;
    localparam int SCORE_W    = 24;
    localparam int RND_W      = 32;
    localparam int TEN_W      = 16;
    localparam int CLS_W      = 23;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 23;

    localparam int MAX_VARS_DEF = 4096;
    localparam int IQ_DEPTH_DEF = 4;
    localparam int OQ_DEPTH_DEF = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_TENURE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAUSES = 2'd1;

    localparam logic [TEN_W-1:0] TENURE_RST  = 16'd10;
    localparam logic [CLS_W-1:0] CLAUSES_RST = 23'd0;

    typedef struct packed {
        logic [TEN_W-1:0] tenure;
        logic [CLS_W-1:0] clauses;
    } t_cfg;

    typedef struct packed {
        logic [VAR_W-1:0]          idx;
        logic signed [SCORE_W-1:0] score;
        logic                      free;
        logic [RND_W-1:0]          rnd;
        logic                      last;
    } t_item;

endpackage

### sv/tbsp_fifo.sv
module tbsp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    output logic                       o_full,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty,
    output logic [$clog2(DEPTH):0]     o_count
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [AW:0]      r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

### sv/tbsp_front.sv
module tbsp_front #(
    parameter int IQ_DEPTH = tbsp_pkg::IQ_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [tbsp_pkg::TEN_W-1:0]           i_tenure,
    input  logic                                 push,
    output logic                                 full,
    input  logic [tbsp_pkg::VAR_W-1:0]           i_var_index,
    input  logic [tbsp_pkg::STEP_W-1:0]          i_var_last_flip,
    input  logic signed [tbsp_pkg::SCORE_W-1:0]  i_var_score,
    input  logic [tbsp_pkg::STEP_W-1:0]          i_current_step,
    input  logic [tbsp_pkg::STEP_W-1:0]          i_reset_step,
    input  logic [tbsp_pkg::RND_W-1:0]           i_random_word,
    input  logic                                 i_is_last,
    output tbsp_pkg::t_item                      o_item,
    output logic                                 o_empty,
    input  logic                                 i_pop
);
    import tbsp_pkg::*;

    localparam int IW = $bits(t_item);

    logic           step_gt_ten;
    logic           flip_lt_rst;
    logic           flip_lt_win;
    logic [STEP_W:0] flip_plus_ten;
    t_item          item;
    logic [IW-1:0]  q_out;

    // A record is free of tabu when its last flip lies before the larger of
    // the reset step and the step minus the tenure; early on only step zero is.
    assign step_gt_ten   = i_current_step > STEP_W'(i_tenure);
    assign flip_lt_rst   = i_var_last_flip < i_reset_step;
    assign flip_plus_ten = {1'b0, i_var_last_flip} + (STEP_W+1)'(i_tenure);
    assign flip_lt_win   = flip_plus_ten < {1'b0, i_current_step};

    always_comb begin
        item.idx   = i_var_index;
        item.score = i_var_score;
        item.free  = step_gt_ten ? (flip_lt_rst || flip_lt_win)
                                 : (i_var_last_flip == '0);
        item.rnd   = i_random_word;
        item.last  = i_is_last;
    end

    tbsp_fifo #(
        .WIDTH (IW),
        .DEPTH (IQ_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (item),
        .o_full  (full),
        .i_pop   (i_pop),
        .o_data  (q_out),
        .o_empty (o_empty),
        .o_count ()
    );

    assign o_item = t_item'(q_out);

endmodule

### sv/tbsp_back.sv
module tbsp_back #(
    parameter int MAX_VARS = tbsp_pkg::MAX_VARS_DEF,
    parameter int OQ_DEPTH = tbsp_pkg::OQ_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [tbsp_pkg::CLS_W-1:0]           i_clauses,
    input  tbsp_pkg::t_item                      i_item,
    input  logic                                 i_q_empty,
    output logic                                 o_q_pop,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [tbsp_pkg::VAR_W-1:0]           o_chosen_var,
    output logic signed [tbsp_pkg::SCORE_W-1:0]  o_best_score,
    output logic [$clog2(MAX_VARS+1)-1:0]        o_candidate_count,
    output logic                                 o_pick_valid
);
    import tbsp_pkg::*;

    localparam int AW    = $clog2(MAX_VARS);
    localparam int CW    = $clog2(MAX_VARS + 1);
    localparam int MW    = AW + 1;
    localparam int MEM_D = 2 ** MW;
    localparam int PW    = RND_W + CW;
    localparam int OCW   = $clog2(OQ_DEPTH) + 1;
    localparam int RW    = VAR_W + SCORE_W + CW + 1;

    logic [VAR_W-1:0] r_mem [MEM_D];

    logic                       r_open;
    logic                       r_bank;
    logic signed [SCORE_W-1:0]  r_best;
    logic [CW-1:0]              r_cnt;

    logic                       r_pk_valid;
    logic [CW-1:0]              r_pk_cnt;
    logic signed [SCORE_W-1:0]  r_pk_best;
    logic [RND_W-1:0]           r_pk_rnd;
    logic                       r_pk_bank;

    logic                       r_rs_valid;
    logic [CW-1:0]              r_rs_cnt;
    logic signed [SCORE_W-1:0]  r_rs_best;
    logic [VAR_W-1:0]           r_rd;

    logic signed [SCORE_W-1:0]  base_best;
    logic [CW-1:0]              base_cnt;
    logic                       hit;
    logic                       better;
    logic [CW-1:0]              cnt_pre;
    logic                       room;
    logic                       wr;
    logic [CW-1:0]              n_cnt;
    logic signed [SCORE_W-1:0]  n_best;
    logic                       take;
    logic                       credit_ok;
    logic [OCW+1:0]             inflight;
    logic [OCW-1:0]             oq_cnt;
    logic [PW-1:0]              prod;
    logic [AW-1:0]              sel;
    logic [RW-1:0]              res_in;
    logic [RW-1:0]              res_out;
    logic                       oq_full;

    // A scan-closing record needs a free output slot before it is taken.
    assign inflight  = (OCW+2)'(r_pk_valid) + (OCW+2)'(r_rs_valid) + (OCW+2)'(oq_cnt);
    assign credit_ok = inflight < (OCW+2)'(OQ_DEPTH);
    assign take      = !i_q_empty && (!i_item.last || credit_ok);
    assign o_q_pop   = take;

    always_comb begin
        base_best = r_open ? r_best : signed'({1'b0, i_clauses});
        base_cnt  = r_open ? r_cnt : '0;
        hit       = i_item.free && (i_item.score <= base_best);
        better    = i_item.score < base_best;
        cnt_pre   = (hit && better) ? '0 : base_cnt;
        room      = cnt_pre < CW'(MAX_VARS);
        wr        = take && hit && room;
        n_cnt     = (hit && room) ? cnt_pre + 1'b1 : cnt_pre;
        n_best    = (hit && better) ? i_item.score : base_best;
    end

    assign prod = PW'(r_pk_rnd) * PW'(r_pk_cnt);
    assign sel  = prod[RND_W +: AW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open     <= 1'b0;
            r_bank     <= 1'b0;
            r_best     <= '0;
            r_cnt      <= '0;
            r_pk_valid <= 1'b0;
            r_rs_valid <= 1'b0;
        end else begin
            if (take) begin
                r_best <= n_best;
                r_cnt  <= n_cnt;
                r_open <= !i_item.last;
                if (i_item.last) begin
                    r_bank <= ~r_bank;
                end
            end
            r_pk_valid <= take && i_item.last;
            r_rs_valid <= r_pk_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_item.last) begin
            r_pk_cnt  <= n_cnt;
            r_pk_best <= n_best;
            r_pk_rnd  <= i_item.rnd;
            r_pk_bank <= r_bank;
        end
        if (r_pk_valid) begin
            r_rs_cnt  <= r_pk_cnt;
            r_rs_best <= r_pk_best;
        end
    end

    // Each scan fills its own half of the tie list, so the pick read of one
    // scan never meets the writes of the scan that follows it.
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[{r_bank, cnt_pre[AW-1:0]}] <= i_item.idx;
        end
        if (r_pk_valid) begin
            r_rd <= r_mem[{r_pk_bank, sel}];
        end
    end

    assign res_in = {((r_rs_cnt != '0) ? r_rd : VAR_W'(0)), r_rs_best, r_rs_cnt,
                     (r_rs_cnt != '0)};

    tbsp_fifo #(
        .WIDTH (RW),
        .DEPTH (OQ_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_rs_valid && !oq_full),
        .i_data  (res_in),
        .o_full  (oq_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty),
        .o_count (oq_cnt)
    );

    assign o_chosen_var      = res_out[RW-1 -: VAR_W];
    assign o_best_score      = signed'(res_out[CW+1 +: SCORE_W]);
    assign o_candidate_count = res_out[1 +: CW];
    assign o_pick_valid      = res_out[0];

endmodule

### sv/tabu_best_score_picker_core.sv
// Channel   Direction  Handshake                 Payload
// records   in         push / full               i_var_index .. i_is_last
// results   out        empty / pop               o_chosen_var .. o_pick_valid
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One record is taken per cycle while the record queue holds one; a scan
// result passes the record queue with the tie update, the pick multiply with
// its tie-list read, and the result queue. Reset is synchronous and needs no
// clearing pass. full rises when the record queue fills;
// a scan-closing record waits while the result queue and the pick stages hold
// as many results as it has slots.
module tabu_best_score_picker_core #(
    parameter int MAX_VARS = tbsp_pkg::MAX_VARS_DEF,
    parameter int IQ_DEPTH = tbsp_pkg::IQ_DEPTH_DEF,
    parameter int OQ_DEPTH = tbsp_pkg::OQ_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [tbsp_pkg::VAR_W-1:0]           i_var_index,
    input  logic [tbsp_pkg::STEP_W-1:0]          i_var_last_flip,
    input  logic signed [tbsp_pkg::SCORE_W-1:0]  i_var_score,
    input  logic [tbsp_pkg::STEP_W-1:0]          i_current_step,
    input  logic [tbsp_pkg::STEP_W-1:0]          i_reset_step,
    input  logic [tbsp_pkg::RND_W-1:0]           i_random_word,
    input  logic                                 i_is_last,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [tbsp_pkg::VAR_W-1:0]           o_chosen_var,
    output logic signed [tbsp_pkg::SCORE_W-1:0]  o_best_score,
    output logic [$clog2(MAX_VARS+1)-1:0]        o_candidate_count,
    output logic                                 o_pick_valid,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [tbsp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tbsp_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import tbsp_pkg::*;

    t_cfg  r_cfg;
    t_item q_item;
    logic  q_empty;
    logic  q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tenure  <= TENURE_RST;
            r_cfg.clauses <= CLAUSES_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_TENURE: begin
                    r_cfg.tenure <= i_cfg_data[TEN_W-1:0];
                end
                CFG_CLAUSES: begin
                    r_cfg.clauses <= i_cfg_data[CLS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    tbsp_front #(
        .IQ_DEPTH (IQ_DEPTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_tenure        (r_cfg.tenure),
        .push            (push),
        .full            (full),
        .i_var_index     (i_var_index),
        .i_var_last_flip (i_var_last_flip),
        .i_var_score     (i_var_score),
        .i_current_step  (i_current_step),
        .i_reset_step    (i_reset_step),
        .i_random_word   (i_random_word),
        .i_is_last       (i_is_last),
        .o_item          (q_item),
        .o_empty         (q_empty),
        .i_pop           (q_pop)
    );

    tbsp_back #(
        .MAX_VARS (MAX_VARS),
        .OQ_DEPTH (OQ_DEPTH)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_clauses         (r_cfg.clauses),
        .i_item            (q_item),
        .i_q_empty         (q_empty),
        .o_q_pop           (q_pop),
        .empty             (empty),
        .pop               (pop),
        .o_chosen_var      (o_chosen_var),
        .o_best_score      (o_best_score),
        .o_candidate_count (o_candidate_count),
        .o_pick_valid      (o_pick_valid)
    );

endmodule
